// ----- hdl/bipolar_encoder_setpoint_and_readback_defines.svh -----
// Assertion macros for the verification-only checker of the setpoint block.
`ifndef BIPOLAR_ENCODER_SETPOINT_AND_READBACK_DEFINES_SVH
`define BIPOLAR_ENCODER_SETPOINT_AND_READBACK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPENC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPENC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bpenc_pkg.sv -----
// Shared types, codes and constants of the bipolar encoder setpoint block.
package bpenc_pkg;

    localparam int MAG_W   = 12;
    localparam int SP_W    = MAG_W + 1;
    localparam int STEP_W  = 8;
    localparam int SLOPE_W = 12;
    localparam int OFFS_W  = 8;
    localparam int VOLT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;

    localparam int SAMPLES_PER_AVERAGE_DEF = 16;

    localparam logic [STEP_W-1:0]  RST_STEP_SIZE       = 8'd15;
    localparam logic [MAG_W-1:0]   RST_MIN_MAGNITUDE   = 12'd240;
    localparam logic [MAG_W-1:0]   RST_MAX_MAGNITUDE   = 12'd3660;
    localparam logic [SLOPE_W-1:0] RST_SLOPE_POSITIVE  = 12'd1750;
    localparam logic [OFFS_W-1:0]  RST_OFFSET_POSITIVE = 8'd58;
    localparam logic [SLOPE_W-1:0] RST_SLOPE_NEGATIVE  = 12'd1876;
    localparam logic [OFFS_W-1:0]  RST_OFFSET_NEGATIVE = 8'd38;

    localparam logic [VOLT_W-2:0] VOLT_MAG_MAX = 15'h7FFF;

    typedef enum logic [1:0] {
        OP_ENCODER = 2'd0,
        OP_SWITCH  = 2'd1,
        OP_ADC     = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        TONE_NONE  = 2'd0,
        TONE_CLICK = 2'd1,
        TONE_LIMIT = 2'd2
    } t_tone;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE       = 3'd0,
        CFG_MIN_MAGNITUDE   = 3'd1,
        CFG_MAX_MAGNITUDE   = 3'd2,
        CFG_SLOPE_POSITIVE  = 3'd3,
        CFG_OFFSET_POSITIVE = 3'd4,
        CFG_SLOPE_NEGATIVE  = 3'd5,
        CFG_OFFSET_NEGATIVE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SP_W-1:0] setpoint;
        logic                   changed;
        logic                   limit;
    } t_step_res;

endpackage

// ----- hdl/bpenc_step.sv -----
// One encoder detent applied to the signed setpoint: band jump and saturation.
module bpenc_step import bpenc_pkg::*; (
    input  logic signed [SP_W-1:0]   i_setpoint,
    input  logic                     i_up,
    input  logic [STEP_W-1:0]        i_step_size,
    input  logic [MAG_W-1:0]         i_min_magnitude,
    input  logic [MAG_W-1:0]         i_max_magnitude,
    output t_step_res                o_res
);

    logic signed [SP_W:0] w_cur;
    logic signed [SP_W:0] w_step;
    logic signed [SP_W:0] w_min;
    logic signed [SP_W:0] w_max;
    logic signed [SP_W:0] w_sum;
    logic signed [SP_W:0] w_next;
    logic                 w_limit;

    assign w_cur  = {i_setpoint[SP_W-1], i_setpoint};
    assign w_step = signed'({{(SP_W+1-STEP_W){1'b0}}, i_step_size});
    assign w_min  = signed'({2'b00, i_min_magnitude});
    assign w_max  = signed'({2'b00, i_max_magnitude});
    assign w_sum  = i_up ? (w_cur + w_step) : (w_cur - w_step);

    always_comb begin
        w_next  = w_sum;
        w_limit = 1'b0;
        // Landing strictly inside the band jumps across it; zero itself is allowed.
        if (!i_up) begin
            if (w_sum > 0 && w_sum < w_min) begin
                w_next = -w_min;
            end else if (w_sum < -w_max) begin
                w_next  = -w_max;
                w_limit = 1'b1;
            end
        end else begin
            if (w_sum < 0 && w_sum > -w_min) begin
                w_next = w_min;
            end else if (w_sum > w_max) begin
                w_next  = w_max;
                w_limit = 1'b1;
            end
        end
    end

    assign o_res.setpoint = w_next[SP_W-1:0];
    assign o_res.changed  = (w_next != w_cur);
    assign o_res.limit    = w_limit;

endmodule

// ----- hdl/bpenc_volt.sv -----
// Scales an averaged ADC count into signed Q8.8 volts with rounding and saturation.
module bpenc_volt import bpenc_pkg::*; (
    input  logic [MAG_W-1:0]          i_average,
    input  logic [SLOPE_W-1:0]        i_slope,
    input  logic [OFFS_W-1:0]         i_offset,
    input  logic                      i_negative,
    output logic signed [VOLT_W-1:0]  o_voltage
);

    localparam int PROD_W = MAG_W + SLOPE_W;

    logic [PROD_W-1:0]   w_prod;
    logic [PROD_W:0]     w_round;
    logic [PROD_W-8:0]   w_q8;
    logic [PROD_W-7:0]   w_mag;
    logic [VOLT_W-2:0]   w_sat;
    logic signed [VOLT_W-1:0] w_pos;

    assign w_prod  = PROD_W'(i_average) * PROD_W'(i_slope);
    assign w_round = {1'b0, w_prod} + (PROD_W+1)'(128);
    assign w_q8    = w_round[PROD_W:8];
    assign w_mag   = {1'b0, w_q8} + (PROD_W-6)'(i_offset);
    assign w_sat   = (w_mag > (PROD_W-6)'(VOLT_MAG_MAX)) ? VOLT_MAG_MAX : w_mag[VOLT_W-2:0];
    assign w_pos   = signed'({1'b0, w_sat});
    assign o_voltage = i_negative ? -w_pos : w_pos;

endmodule

// ----- hdl/bipolar_encoder_setpoint_and_readback.sv -----
// Top level: encoder-driven bipolar setpoint with averaged, scaled ADC readback.
// The block takes one input beat per clock cycle until it stalls as described below, and
// presents each result from the output register. Beats pass an input register, a middle
// register and the output register. Each stage moves whenever the one after it is empty or
// moving, so bubbles are squeezed out. While a finished result waits on the output, beats are
// still taken until the input and middle registers are full; then the input stalls.
// The longest paths are the reciprocal multiply that turns the sample sum into the
// average (input to middle stage) and the slope multiply with rounding, offset and
// saturation (middle to output stage). Encoder and switch beats always give one result;
// ADC beats give one only when they complete a block of samples whose truncated average
// differs from the previous block. Operation code 3 is dropped without a result.
module bipolar_encoder_setpoint_and_readback import bpenc_pkg::*; #(
    parameter int SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // [0] clock_level, [1] data_level, [13:2] adc_sample, [15:14] zero
    input  logic [IN_DATA_W-1:0]     i_s_tdata,
    // [1:0] operation
    input  logic [IN_USER_W-1:0]     i_s_tuser,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // [11:0] dac_code, [12] polarity_negative, [13] setpoint_changed, [29:14] voltage,
    // [31:30] zero
    output logic [OUT_DATA_W-1:0]    o_m_tdata,
    // [1:0] tone_kind, [2] voltage_valid
    output logic [OUT_USER_W-1:0]    o_m_tuser,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CNT_W  = $clog2(SAMPLES_PER_AVERAGE);
    localparam int SUM_W  = MAG_W + CNT_W;
    localparam int SHIFT  = SUM_W + CNT_W;
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    // Rounded-up reciprocal; exact floor division for every sum below 2**SUM_W.
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((1 << SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    // Configuration registers.
    logic [STEP_W-1:0]  r_step_size;
    logic [MAG_W-1:0]   r_min_magnitude;
    logic [MAG_W-1:0]   r_max_magnitude;
    logic [SLOPE_W-1:0] r_slope_positive;
    logic [OFFS_W-1:0]  r_offset_positive;
    logic [SLOPE_W-1:0] r_slope_negative;
    logic [OFFS_W-1:0]  r_offset_negative;

    // Block state.
    logic signed [SP_W-1:0] r_setpoint, n_setpoint;
    logic                   r_polarity, n_polarity;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [MAG_W-1:0]       r_last_avg;

    // Input stage.
    logic               r_s1_valid;
    t_op                r_s1_op;
    logic               r_s1_clock_level;
    logic               r_s1_data_level;
    logic [MAG_W-1:0]   r_s1_sample;

    // Middle stage.
    logic               r_s2_valid, n_s2_valid;
    logic               r_s2_is_adc, n_s2_is_adc;
    logic [MAG_W-1:0]   r_s2_dac, n_s2_dac;
    logic               r_s2_pol;
    logic               r_s2_changed, n_s2_changed;
    t_tone              r_s2_tone, n_s2_tone;
    logic [MAG_W-1:0]   r_s2_avg;
    logic [SLOPE_W-1:0] r_s2_slope;
    logic [OFFS_W-1:0]  r_s2_offset;

    // Output stage.
    logic                    r_out_valid;
    logic [MAG_W-1:0]        r_out_dac;
    logic                    r_out_pol;
    logic                    r_out_changed;
    t_tone                   r_out_tone;
    logic                    r_out_vvalid;
    logic signed [VOLT_W-1:0] r_out_voltage;

    logic w_out_free, w_s2_free, w_s1_free;
    logic w_s1_move, w_s2_move, w_in_take, w_has_result;
    t_step_res               w_step;
    logic [SUM_W-1:0]        w_sum_acc;
    logic [PROD_W-1:0]       w_prod;
    logic [MAG_W-1:0]        w_avg;
    logic [SP_W-1:0]         w_abs;
    logic signed [VOLT_W-1:0] w_voltage;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_s2_move  = r_s2_valid && w_out_free;
    assign w_s2_free  = !r_s2_valid || w_out_free;
    assign w_s1_move  = r_s1_valid && w_s2_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;
    assign o_s_tready = w_s1_free;
    assign w_in_take  = i_s_tvalid && w_s1_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size       <= RST_STEP_SIZE;
            r_min_magnitude   <= RST_MIN_MAGNITUDE;
            r_max_magnitude   <= RST_MAX_MAGNITUDE;
            r_slope_positive  <= RST_SLOPE_POSITIVE;
            r_offset_positive <= RST_OFFSET_POSITIVE;
            r_slope_negative  <= RST_SLOPE_NEGATIVE;
            r_offset_negative <= RST_OFFSET_NEGATIVE;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_STEP_SIZE:       r_step_size       <= i_cfg_data[STEP_W-1:0];
                CFG_MIN_MAGNITUDE:   r_min_magnitude   <= i_cfg_data[MAG_W-1:0];
                CFG_MAX_MAGNITUDE:   r_max_magnitude   <= i_cfg_data[MAG_W-1:0];
                CFG_SLOPE_POSITIVE:  r_slope_positive  <= i_cfg_data[SLOPE_W-1:0];
                CFG_OFFSET_POSITIVE: r_offset_positive <= i_cfg_data[OFFS_W-1:0];
                CFG_SLOPE_NEGATIVE:  r_slope_negative  <= i_cfg_data[SLOPE_W-1:0];
                CFG_OFFSET_NEGATIVE: r_offset_negative <= i_cfg_data[OFFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bpenc_step u_step (
        .i_setpoint      (r_setpoint),
        .i_up            (r_s1_data_level),
        .i_step_size     (r_step_size),
        .i_min_magnitude (r_min_magnitude),
        .i_max_magnitude (r_max_magnitude),
        .o_res           (w_step)
    );

    assign w_sum_acc = r_sum + SUM_W'(r_s1_sample);
    assign w_prod    = PROD_W'(w_sum_acc) * PROD_W'(RECIP);
    assign w_avg     = w_prod[SHIFT +: MAG_W];

    always_comb begin
        n_setpoint   = r_setpoint;
        n_polarity   = r_polarity;
        n_sum        = r_sum;
        n_count      = r_count;
        n_s2_valid   = 1'b0;
        n_s2_is_adc  = 1'b0;
        n_s2_changed = 1'b0;
        n_s2_tone    = TONE_CLICK;
        case (r_s1_op)
            OP_ENCODER: begin
                n_s2_valid = 1'b1;
                // A high clock level is a bounce edge: report it without moving.
                if (!r_s1_clock_level) begin
                    n_setpoint   = w_step.setpoint;
                    n_s2_changed = w_step.changed;
                    n_s2_tone    = w_step.limit ? TONE_LIMIT : TONE_CLICK;
                    if (w_step.changed) begin
                        n_polarity = w_step.setpoint[SP_W-1];
                    end
                end
            end
            OP_SWITCH: begin
                n_s2_valid   = 1'b1;
                n_setpoint   = signed'({1'b0, r_min_magnitude});
                n_polarity   = 1'b0;
                n_s2_changed = 1'b1;
            end
            OP_ADC: begin
                n_s2_is_adc = 1'b1;
                n_s2_tone   = TONE_NONE;
                if (r_count == CNT_W'(SAMPLES_PER_AVERAGE - 1)) begin
                    n_s2_valid = 1'b1;
                    n_sum      = '0;
                    n_count    = '0;
                end else begin
                    n_sum   = w_sum_acc;
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign w_abs    = n_setpoint[SP_W-1] ? -n_setpoint : n_setpoint;
    assign n_s2_dac = w_abs[MAG_W-1:0];

    bpenc_volt u_volt (
        .i_average  (r_s2_avg),
        .i_slope    (r_s2_slope),
        .i_offset   (r_s2_offset),
        .i_negative (r_s2_pol),
        .o_voltage  (w_voltage)
    );

    assign w_has_result = !r_s2_is_adc || (r_s2_avg != r_last_avg);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= signed'({1'b0, RST_MIN_MAGNITUDE});
            r_polarity  <= 1'b0;
            r_sum       <= '0;
            r_count     <= '0;
            r_last_avg  <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_setpoint <= n_setpoint;
                r_polarity <= n_polarity;
                r_sum      <= n_sum;
                r_count    <= n_count;
                r_s2_valid <= n_s2_valid;
            end else if (w_s2_move) begin
                r_s2_valid <= 1'b0;
            end
            if (w_s2_move) begin
                r_out_valid <= w_has_result;
                if (r_s2_is_adc) begin
                    r_last_avg <= r_s2_avg;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_op          <= t_op'(i_s_tuser[1:0]);
            r_s1_clock_level <= i_s_tdata[0];
            r_s1_data_level  <= i_s_tdata[1];
            r_s1_sample      <= i_s_tdata[MAG_W+1:2];
        end
        if (w_s1_move) begin
            r_s2_is_adc  <= n_s2_is_adc;
            r_s2_dac     <= n_s2_dac;
            r_s2_pol     <= n_polarity;
            r_s2_changed <= n_s2_changed;
            r_s2_tone    <= n_s2_tone;
            r_s2_avg     <= w_avg;
            r_s2_slope   <= r_polarity ? r_slope_negative : r_slope_positive;
            r_s2_offset  <= r_polarity ? r_offset_negative : r_offset_positive;
        end
        if (w_s2_move) begin
            r_out_dac     <= r_s2_dac;
            r_out_pol     <= r_s2_pol;
            r_out_changed <= r_s2_changed;
            r_out_tone    <= r_s2_tone;
            r_out_vvalid  <= r_s2_is_adc;
            r_out_voltage <= r_s2_is_adc ? w_voltage : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_voltage, r_out_changed, r_out_pol, r_out_dac};
    assign o_m_tuser  = {r_out_vvalid, r_out_tone};

endmodule

// ----- hdl/bpenc_checker.sv -----
// Port-level checker for the setpoint block, bound to the top level.
`include "bipolar_encoder_setpoint_and_readback_defines.svh"

module bpenc_checker import bpenc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_DATA_W-1:0]  o_m_tdata,
    input logic [OUT_USER_W-1:0]  o_m_tuser
);

    logic                               w_volt_beat;
    logic                               w_sp_beat;
    logic                               w_quiet;
    logic                               w_sp_ok;
    logic                               w_zero_beat;
    logic                               w_stalled;
    logic [OUT_DATA_W+OUT_USER_W:0]     w_out_beat;

    assign w_volt_beat = o_m_tvalid && o_m_tuser[2];
    assign w_sp_beat   = o_m_tvalid && !o_m_tuser[2];
    assign w_quiet     = !o_m_tdata[13] && (o_m_tuser[1:0] == TONE_NONE);
    assign w_sp_ok     = (o_m_tdata[29:14] == 16'd0) && (o_m_tuser[1:0] != TONE_NONE);
    assign w_zero_beat = o_m_tvalid && (o_m_tdata[11:0] == 12'd0);
    assign w_stalled   = o_m_tvalid && !i_m_tready;
    assign w_out_beat  = {o_m_tvalid, o_m_tuser, o_m_tdata};

    // A voltage report never claims a setpoint update or a tone.
    `BPENC_ASSERT_IMP(a_volt_quiet, w_volt_beat, w_quiet, "voltage beat with update or tone")

    // Setpoint beats carry a tone and a zero voltage field.
    `BPENC_ASSERT_IMP(a_setpoint_beat, w_sp_beat, w_sp_ok, "setpoint beat with voltage or no tone")

    // A zero setpoint always counts as positive.
    `BPENC_ASSERT_IMP(a_zero_positive, w_zero_beat, !o_m_tdata[12], "zero magnitude as negative")

    // A stalled beat holds until it is taken.
    `BPENC_ASSERT_NXT(a_out_hold, w_stalled, $stable(w_out_beat), "stalled output beat changed")

    // The input is refused only while a finished beat waits on the output.
    `BPENC_ASSERT_IMP(a_in_stall, !o_s_tready, w_stalled, "input refused with output free")

endmodule

bind bipolar_encoder_setpoint_and_readback bpenc_checker u_bpenc_checker (.*);

// ----- verif/setpoint_readback_checker.sv -----
// Checker for the setpoint block: tracks its state, predicts each readout and compares.
module setpoint_readback_checker import bpenc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic [OUT_USER_W-1:0] i_m_tuser,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_readouts,
    output int                    o_voltages,
    output int                    o_limits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MAG_W-1:0]  dac_code;
        logic              negative;
        logic              changed;
        logic [1:0]        tone;
        logic              volt_valid;
        logic [VOLT_W-1:0] voltage;
    } t_readout;

    t_readout readouts_due[$];

    logic [STEP_W-1:0]      step_size;
    logic [MAG_W-1:0]       min_mag;
    logic [MAG_W-1:0]       max_mag;
    logic [SLOPE_W-1:0]     slope_pos;
    logic [OFFS_W-1:0]      offs_pos;
    logic [SLOPE_W-1:0]     slope_neg;
    logic [OFFS_W-1:0]      offs_neg;

    logic signed [SP_W-1:0] setpoint;
    logic                   negative;
    logic [15:0]            sample_sum;
    int                     sample_count;
    logic [MAG_W-1:0]       last_average;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_readouts   = 0;
        o_voltages   = 0;
        o_limits     = 0;
    end

    function automatic t_readout readout_now(logic changed, logic [1:0] tone,
                                             logic volt_valid, int volts);
        t_readout r;
        int s;
        s            = setpoint;
        r.dac_code   = MAG_W'(s < 0 ? -s : s);
        r.negative   = negative;
        r.changed    = changed;
        r.tone       = tone;
        r.volt_valid = volt_valid;
        r.voltage    = VOLT_W'(volts);
        return r;
    endfunction

    task automatic step_setpoint(logic clk_level, logic data_level);
        int  s;
        int  prev;
        int  mn;
        int  mx;
        logic limit;
        prev   = setpoint;
        s      = prev;
        mn     = int'(min_mag);
        mx     = int'(max_mag);
        limit  = 1'b0;
        if (clk_level) begin
            readouts_due.push_back(readout_now(1'b0, TONE_CLICK, 1'b0, 0));
            return;
        end
        // A step landing strictly inside the forbidden band jumps across it,
        // with no saturation check after the jump.
        if (!data_level) begin
            s = s - int'(step_size);
            if (s > 0 && s < mn) begin
                s = -mn;
            end else if (s < -mx) begin
                s = -mx;
                limit = 1'b1;
            end
        end else begin
            s = s + int'(step_size);
            if (s < 0 && s > -mn) begin
                s = mn;
            end else if (s > mx) begin
                s = mx;
                limit = 1'b1;
            end
        end
        setpoint = SP_W'(s);
        if (s != prev)
            negative = (s < 0);
        readouts_due.push_back(readout_now(s != prev, limit ? TONE_LIMIT : TONE_CLICK,
                                           1'b0, 0));
    endtask

    task automatic accumulate_sample(logic [MAG_W-1:0] sample);
        logic [MAG_W-1:0]   avg;
        logic [SLOPE_W-1:0] slope;
        logic [OFFS_W-1:0]  offs;
        int                 scaled;
        sample_sum = sample_sum + 16'(sample);
        sample_count++;
        if (sample_count < SAMPLES_PER_AVERAGE_DEF)
            return;
        avg          = MAG_W'(sample_sum / SAMPLES_PER_AVERAGE_DEF);
        sample_sum   = '0;
        sample_count = 0;
        if (avg == last_average)
            return;
        last_average = avg;
        slope  = negative ? slope_neg : slope_pos;
        offs   = negative ? offs_neg : offs_pos;
        scaled = ((int'(avg) * int'(slope) + 128) >> 8) + int'(offs);
        if (scaled > 32767)
            scaled = 32767;
        readouts_due.push_back(readout_now(1'b0, TONE_NONE, 1'b1,
                                           negative ? -scaled : scaled));
    endtask

    task automatic predict_beat(logic [1:0] op, logic clk_level, logic data_level,
                                logic [MAG_W-1:0] sample);
        case (op)
            OP_ENCODER: begin
                step_setpoint(clk_level, data_level);
            end
            OP_SWITCH: begin
                setpoint = SP_W'(min_mag);
                negative = 1'b0;
                readouts_due.push_back(readout_now(1'b1, TONE_CLICK, 1'b0, 0));
            end
            OP_ADC: begin
                accumulate_sample(sample);
            end
            default: ;
        endcase
    endtask

    task automatic check_readout(t_readout got);
        t_readout want;
        if (readouts_due.size() == 0) begin
            if (o_mismatches < 10)
                $display("%0t: unexpected readout dac=%0d neg=%0b chg=%0b tone=%0d vv=%0b v=%0d",
                         $realtime, got.dac_code, got.negative, got.changed, got.tone,
                         got.volt_valid, $signed(got.voltage));
            o_mismatches++;
            return;
        end
        want = readouts_due.pop_front();
        if (got.dac_code !== want.dac_code || got.negative !== want.negative ||
            got.changed !== want.changed || got.tone !== want.tone ||
            got.volt_valid !== want.volt_valid || got.voltage !== want.voltage) begin
            if (o_mismatches < 10) begin
                $display("%0t: readout mismatch, expected dac=%0d neg=%0b chg=%0b tone=%0d",
                         $realtime, want.dac_code, want.negative, want.changed, want.tone);
                $display("    vv=%0b v=%0d; got dac=%0d neg=%0b chg=%0b tone=%0d vv=%0b v=%0d",
                         want.volt_valid, $signed(want.voltage), got.dac_code, got.negative,
                         got.changed, got.tone, got.volt_valid, $signed(got.voltage));
            end
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_size    = RST_STEP_SIZE;
            min_mag      = RST_MIN_MAGNITUDE;
            max_mag      = RST_MAX_MAGNITUDE;
            slope_pos    = RST_SLOPE_POSITIVE;
            offs_pos     = RST_OFFSET_POSITIVE;
            slope_neg    = RST_SLOPE_NEGATIVE;
            offs_neg     = RST_OFFSET_NEGATIVE;
            setpoint     = SP_W'(RST_MIN_MAGNITUDE);
            negative     = 1'b0;
            sample_sum   = '0;
            sample_count = 0;
            last_average = '0;
            readouts_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STEP_SIZE:       step_size = i_cfg_data[STEP_W-1:0];
                    CFG_MIN_MAGNITUDE:   min_mag   = i_cfg_data[MAG_W-1:0];
                    CFG_MAX_MAGNITUDE:   max_mag   = i_cfg_data[MAG_W-1:0];
                    CFG_SLOPE_POSITIVE:  slope_pos = i_cfg_data[SLOPE_W-1:0];
                    CFG_OFFSET_POSITIVE: offs_pos  = i_cfg_data[OFFS_W-1:0];
                    CFG_SLOPE_NEGATIVE:  slope_neg = i_cfg_data[SLOPE_W-1:0];
                    CFG_OFFSET_NEGATIVE: offs_neg  = i_cfg_data[OFFS_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_beat(i_s_tuser[1:0], i_s_tdata[0], i_s_tdata[1], i_s_tdata[13:2]);
            if (i_m_tvalid && i_m_tready) begin
                check_readout('{dac_code:   i_m_tdata[11:0],
                                negative:   i_m_tdata[12],
                                changed:    i_m_tdata[13],
                                tone:       i_m_tuser[1:0],
                                volt_valid: i_m_tuser[2],
                                voltage:    i_m_tdata[29:14]});
                o_readouts++;
                if (i_m_tuser[2])
                    o_voltages++;
                if (i_m_tuser[1:0] == TONE_LIMIT)
                    o_limits++;
            end
        end
        o_pending = readouts_due.size();
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the setpoint block testbench: clock, reset, stimulus, flow control and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bpenc_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         PHASES        = 12;
    localparam int         BEATS_PER_PHASE = 145;
    localparam int         HOLD_PHASE    = 4;
    localparam int         STEADY_PHASE  = 6;
    localparam int         HOLD_CYCLES   = 80;
    // Pipeline is three stages deep; the quiet cycles cover beats without a result.
    localparam int         QUIET_CYCLES  = 8;
    localparam int         WATCHDOG_LIMIT = 1000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   mismatches;
    int   pending;
    int   readouts;
    int   voltages;
    int   limits;
    int   beats_sent   = 0;
    int   stall_cycles = 0;
    logic steady       = 1'b0;
    logic hold_wanted  = 1'b0;
    logic hold_served  = 1'b0;

    always #10 clk = ~clk;

    bipolar_encoder_setpoint_and_readback #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE_DEF)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    setpoint_readback_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_readouts   (readouts),
        .o_voltages   (voltages),
        .o_limits     (limits)
    );

    // Result side: random back-pressure, plus one long hold-off once requested.
    initial begin : readout_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_wanted && !hold_served) begin
                hold_left   = HOLD_CYCLES;
                hold_served = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: no beat moved for %0d cycles, %0d readouts outstanding",
                     stall_cycles, pending);
            $display("testbench: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_beat(logic [1:0] op, logic clk_level, logic data_level,
                             logic [MAG_W-1:0] sample);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, sample, data_level, clk_level};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic wait_drained;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(t_cfg_idx idx, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(int step, int mn, int mx, int sp, int opos,
                                  int sn, int oneg);
        wait_drained();
        write_register(CFG_STEP_SIZE, step);
        write_register(CFG_MIN_MAGNITUDE, mn);
        write_register(CFG_MAX_MAGNITUDE, mx);
        write_register(CFG_SLOPE_POSITIVE, sp);
        write_register(CFG_OFFSET_POSITIVE, opos);
        write_register(CFG_SLOPE_NEGATIVE, sn);
        write_register(CFG_OFFSET_NEGATIVE, oneg);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int               phase;
        int               k;
        int               pick;
        int               dir_left;
        int               adc_style;
        int               adc_level;
        int               noisy;
        int               mn;
        logic             going_up;
        logic             clk_level;
        logic             data_level;
        logic [1:0]       op;
        logic [MAG_W-1:0] sample;

        dir_left  = 0;
        going_up  = 1'b1;
        adc_level = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    // Reset settings: clock-high edges, band jumps both ways, unused code.
                    send_beat(OP_SWITCH, 1'b0, 1'b0, 12'h000);
                    send_beat(OP_ENCODER, 1'b1, 1'b0, 12'($urandom));
                    send_beat(OP_ENCODER, 1'b1, 1'b1, 12'($urandom));
                    send_beat(OP_ENCODER, 1'b0, 1'b0, 12'($urandom));
                    send_beat(OP_ENCODER, 1'b0, 1'b1, 12'($urandom));
                    send_beat(OP_ENCODER, 1'b0, 1'b1, 12'($urandom));
                    send_beat(OP_UNUSED, 1'b1, 1'b1, 12'hFFF);
                    send_beat(OP_ADC, 1'b0, 1'b0, 12'h000);
                    send_beat(OP_ADC, 1'b1, 1'b1, 12'hFFF);
                end
                1: begin
                    // No forbidden band; a step lands exactly on zero.
                    apply_settings(240, 0, 4095, 4095, 255, 4095, 255);
                    send_beat(OP_SWITCH, 1'b1, 1'b1, 12'($urandom));
                    send_beat(OP_ENCODER, 1'b0, 1'b0, 12'($urandom));
                    send_beat(OP_ENCODER, 1'b0, 1'b1, 12'($urandom));
                    send_beat(OP_ENCODER, 1'b0, 1'b0, 12'($urandom));
                end
                2: begin
                    // Minimum above maximum: saturation at zero and jumps past the limit.
                    apply_settings(1, 4095, 0, 0, 0, 0, 0);
                    send_beat(OP_SWITCH, 1'b0, 1'b0, 12'($urandom));
                    send_beat(OP_ENCODER, 1'b0, 1'b1, 12'($urandom));
                    send_beat(OP_ENCODER, 1'b0, 1'b0, 12'($urandom));
                    send_beat(OP_SWITCH, 1'b0, 1'b0, 12'($urandom));
                    send_beat(OP_ENCODER, 1'b0, 1'b0, 12'($urandom));
                    send_beat(OP_ENCODER, 1'b0, 1'b1, 12'($urandom));
                end
                default: begin
                    mn = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, 600);
                    apply_settings($urandom_range(0, 1) ? $urandom_range(1, 40)
                                                        : $urandom_range(1, 255),
                                   mn,
                                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                               : $urandom_range(mn, 4095),
                                   $urandom_range(0, 4095), $urandom_range(0, 255),
                                   $urandom_range(0, 4095), $urandom_range(0, 255));
                end
            endcase
            steady    = (phase == STEADY_PHASE);
            adc_style = $urandom_range(0, 2);

            for (k = 0; k < BEATS_PER_PHASE; k++) begin
                if (dir_left == 0) begin
                    going_up = 1'($urandom_range(0, 1));
                    dir_left = $urandom_range(1, 40);
                end
                clk_level  = 1'($urandom_range(0, 1));
                data_level = 1'($urandom_range(0, 1));
                case (adc_style)
                    0: sample = MAG_W'($urandom_range(0, 4095));
                    1: sample = MAG_W'(adc_level);
                    default: begin
                        noisy  = adc_level + int'($urandom_range(0, 6)) - 3;
                        sample = MAG_W'(noisy < 0 ? 0 : (noisy > 4095 ? 4095 : noisy));
                    end
                endcase
                if ($urandom_range(0, 39) == 0)
                    adc_level = $urandom_range(0, 4095);
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    // Encoder edges run in one direction for a while to reach the limits.
                    op         = OP_ENCODER;
                    clk_level  = ($urandom_range(0, 9) == 0);
                    data_level = ($urandom_range(0, 7) == 0) ? !going_up : going_up;
                    dir_left--;
                end else if (pick < 50) begin
                    op = OP_SWITCH;
                end else if (pick < 96) begin
                    op = OP_ADC;
                end else begin
                    op = OP_UNUSED;
                end
                send_beat(op, clk_level, data_level, sample);
                if (phase == HOLD_PHASE && k == 20)
                    hold_wanted = 1'b1;
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (QUIET_CYCLES) @(posedge clk);
        $display("testbench: %0d beats over %0d setting phases, %0d readouts checked",
                 beats_sent, PHASES, readouts);
        $display("testbench: %0d voltage reports, %0d limit tones", voltages, limits);
        if (mismatches == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
